// ===== hw/rtl/utf8_lowercase_stream_macros.svh =====
// utf8_lowercase_stream_macros.svh: assertion macros for the UTF-8 lowercaser checker.
// Depends on nothing. Included by the checker file.
`ifndef UTF8_LOWERCASE_STREAM_MACROS_SVH
`define UTF8_LOWERCASE_STREAM_MACROS_SVH

// same-cycle implication, disabled during reset
`define UTF8LC_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("utf8lc: implication failed");

// next-cycle implication, disabled during reset
`define UTF8LC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("utf8lc: next-cycle implication failed");

// implication checked also while reset is high
`define UTF8LC_ASSERT_ALWAYS(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |-> (c)) \
    else $error("utf8lc: unconditional implication failed");

`endif

// ===== hw/rtl/utf8lc_pkg.sv =====
// utf8lc_pkg: shared types, codes and helpers of the UTF-8 lowercaser.
// Depends on nothing; imported by every module of the block except utf8lc_checker.
`default_nettype none

package utf8lc_pkg;

  // lowercase map geometry, fixed by the map_index field
  localparam int MAP_DEPTH = 1920;
  localparam int MAP_AW    = 11;
  localparam int MAP_DW    = 11;

  // default depth of the queue between front and back
  localparam int FIFO_DEPTH = 4;

  // request kinds on the func field
  localparam logic FUNC_TEXT = 1'b0;
  localparam logic FUNC_MAP  = 1'b1;

  typedef logic [2:0][7:0] byte3_t;

  // one decoded job: up to three output bytes
  typedef struct packed {
    byte3_t     bytes;
    logic [1:0] count;   // 1..3 bytes
    logic       last;    // job comes from the final byte of the text
  } job_t;

  // queue status seen by the front
  typedef struct packed {
    logic empty;
    logic room1;   // at least one free slot
    logic room2;   // at least two free slots
  } fifo_stat_t;

  function automatic logic [7:0] ascii_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) r = b + 8'h20;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/utf8_lowercase_stream.sv =====
// utf8_lowercase_stream: top level of the streaming UTF-8 lowercaser.
// Depends on utf8lc_pkg, utf8lc_front, utf8lc_fifo and utf8lc_back.
//
// The block takes one request per cycle unless in_stall is high: a text byte (func 0)
// or a write of one lowercase map entry (func 1). Each text byte yields zero to three
// output bytes, which leave on the single-byte output port one per cycle while
// out_stall is low; ASCII text streams at one byte per cycle when neither side
// stalls. Output bytes pass through the result stage, where map reads resolve, and
// then the queue. After reset the 1920-entry map is swept to zero, one entry per
// cycle, and in_stall stays high until the sweep ends. A queue of FIFO_DEPTH_P jobs
// separates the decoder from the output side.
`default_nettype none

module utf8_lowercase_stream
  import utf8lc_pkg::*;
#(
  parameter int FIFO_DEPTH_P = FIFO_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               func,
  input  wire logic [7:0]         in_byte,
  input  wire logic               last_byte,
  input  wire logic [MAP_AW-1:0]  map_index,
  input  wire logic [MAP_DW-1:0]  map_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    run_last,
  output logic                    text_last
);

  fifo_stat_t fstat;
  logic       job_valid;
  job_t       job;
  job_t       head;
  logic       pop;

  // decode and map lookup
  utf8lc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .map_index (map_index),
    .map_value (map_value),
    .fstat     (fstat),
    .job_valid (job_valid),
    .job       (job)
  );

  // job queue
  utf8lc_fifo #(
    .DEPTH (FIFO_DEPTH_P)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_valid),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .fstat    (fstat)
  );

  // byte emitter
  utf8lc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!fstat.empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .text_last  (text_last)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/utf8lc_front.sv =====
// utf8lc_front: accepts requests, tracks UTF-8 sequence state, owns the lowercase map
// and a result stage that resolves map lookups. Depends on utf8lc_pkg.
`default_nettype none

module utf8lc_front
  import utf8lc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               func,
  input  wire logic [7:0]         in_byte,
  input  wire logic               last_byte,
  input  wire logic [MAP_AW-1:0]  map_index,
  input  wire logic [MAP_DW-1:0]  map_value,
  input  wire fifo_stat_t         fstat,
  output logic                    job_valid,
  output job_t                    job
);

  localparam logic [1:0] HC_NONE = 2'd0;
  localparam logic [1:0] HC_LEAD = 2'd1;
  localparam logic [1:0] HC_TWO  = 2'd2;

  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] ASCII_END = 8'h80;
  localparam logic [MAP_AW-1:0] CP_BASE = MAP_AW'(8'h80);

  // fixed three-byte rules
  function automatic byte3_t finish_three(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2);
    byte3_t o;
    o[0] = b0;
    o[1] = b1;
    o[2] = b2;
    if (b0 == 8'hE1) begin
      if (b1 == 8'h82 && b2 >= 8'hA0) begin
        o[0] = 8'hE2; o[1] = 8'hB4; o[2] = b2 - 8'h20;
      end else if (b1 == 8'h83 && b2 >= 8'h80 && b2 <= 8'h85) begin
        o[0] = 8'hE2; o[1] = 8'hB4; o[2] = b2 + 8'h20;
      end else if (b1 >= 8'hB8 && b1 <= 8'hBB && !b2[0] &&
                   !(b1 == 8'hBA && b2 == 8'h9E)) begin
        o[2] = b2 + 8'h01;
      end
    end else if (b0 == 8'hEF && b1 == 8'hBC && b2 >= 8'hA1 && b2 <= 8'hBA) begin
      o[1] = 8'hBD; o[2] = b2 - 8'h20;
    end
    return o;
  endfunction

  // sequence state
  logic [7:0] held_lead, held_lead_next;
  logic [7:0] held_second, held_second_next;
  logic [1:0] held_count, held_count_next;
  logic [1:0] raw_copy_left, raw_copy_left_next;

  // map clearing pass
  logic              clearing;
  logic [MAP_AW-1:0] clr_addr;

  // map memory
  logic [MAP_DW-1:0] lower_map [MAP_DEPTH];
  logic [MAP_DW-1:0] rd_data;
  logic              rd_en;
  logic [MAP_AW-1:0] rd_addr;
  logic              map_we;
  logic [7:0]        lead_off;

  // decode results
  logic              accept, text_acc;
  byte3_t            em_bytes;
  logic [1:0]        em_cnt;
  logic              em_map2;

  // result stage
  logic              s1_valid;
  job_t              s1_job;
  logic              s1_map2;
  logic [MAP_AW-1:0] s1_cp;
  logic [MAP_AW-1:0] cp;

  // stall while clearing or the queue may lack room for the stage and a new job
  always_comb begin
    in_stall = clearing || (s1_valid ? !fstat.room2 : !fstat.room1);
  end

  assign accept   = in_valid && !in_stall;
  assign text_acc = accept && (func == FUNC_TEXT);
  assign map_we   = accept && (func == FUNC_MAP) && (map_index < MAP_AW'(MAP_DEPTH));
  assign lead_off = held_lead - LEAD2_MIN;
  assign rd_addr  = {lead_off[4:0], in_byte[5:0]};

  // sequence decode
  always_comb begin
    held_lead_next     = held_lead;
    held_second_next   = held_second;
    held_count_next    = held_count;
    raw_copy_left_next = raw_copy_left;
    em_bytes           = '0;
    em_cnt             = 2'd0;
    em_map2            = 1'b0;
    rd_en              = 1'b0;
    if (text_acc) begin
      if (raw_copy_left != 2'd0) begin
        em_bytes[0]        = in_byte;
        em_cnt             = 2'd1;
        raw_copy_left_next = raw_copy_left - 2'd1;
      end else if (held_count == HC_LEAD) begin
        if (held_lead < LEAD3_MIN) begin
          // two-byte sequence: map lookup, bytes resolved in the result stage
          em_map2         = 1'b1;
          em_cnt          = 2'd2;
          rd_en           = 1'b1;
          held_count_next = HC_NONE;
        end else if (last_byte) begin
          // three-byte lead cut short: flush lead, then the last byte on its own
          em_bytes[0]     = held_lead;
          em_bytes[1]     = ascii_lower(in_byte);
          em_cnt          = 2'd2;
          held_count_next = HC_NONE;
        end else begin
          held_second_next = in_byte;
          held_count_next  = HC_TWO;
        end
      end else if (held_count == HC_TWO) begin
        em_bytes        = finish_three(held_lead, held_second, in_byte);
        em_cnt          = 2'd3;
        held_count_next = HC_NONE;
      end else begin
        held_count_next = HC_NONE;
        if (in_byte < ASCII_END) begin
          em_bytes[0] = ascii_lower(in_byte);
          em_cnt      = 2'd1;
        end else if (in_byte < LEAD2_MIN || last_byte) begin
          em_bytes[0] = in_byte;
          em_cnt      = 2'd1;
        end else if (in_byte < LEAD4_MIN) begin
          held_lead_next  = in_byte;
          held_count_next = HC_LEAD;
        end else begin
          em_bytes[0]        = in_byte;
          em_cnt             = 2'd1;
          raw_copy_left_next = 2'd3;
        end
      end
      if (last_byte) begin
        held_count_next    = HC_NONE;
        raw_copy_left_next = 2'd0;
      end
    end
  end

  // sequence state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead     <= '0;
      held_second   <= '0;
      held_count    <= HC_NONE;
      raw_copy_left <= '0;
    end else begin
      held_lead     <= held_lead_next;
      held_second   <= held_second_next;
      held_count    <= held_count_next;
      raw_copy_left <= raw_copy_left_next;
    end
  end

  // clearing pass over the map after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == MAP_AW'(MAP_DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clearing) begin
      lower_map[clr_addr] <= '0;
    end else if (map_we) begin
      lower_map[map_index] <= map_value;
    end
    if (rd_en) begin
      rd_data <= lower_map[rd_addr];
    end
  end

  // result stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= text_acc && (em_cnt != 2'd0);
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (text_acc) begin
      s1_job.bytes <= em_bytes;
      s1_job.count <= em_cnt;
      s1_job.last  <= last_byte;
      s1_map2      <= em_map2;
      s1_cp        <= rd_addr + CP_BASE;
    end
  end

  // resolve map lookups and re-encode as two bytes
  always_comb begin
    cp  = (rd_data != '0) ? rd_data : s1_cp;
    job = s1_job;
    if (s1_map2) begin
      job.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
      job.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
      job.bytes[2] = 8'h00;
    end
  end

  assign job_valid = s1_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8lc_fifo.sv =====
// utf8lc_fifo: short job queue between front and back of the UTF-8 lowercaser.
// Depends on utf8lc_pkg for job_t and fifo_stat_t.
`default_nettype none

module utf8lc_fifo
  import utf8lc_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire job_t  push_job,
  input  wire logic  pop,
  output job_t       head,
  output fifo_stat_t fstat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  // pointer and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  assign head = entries[rd_ptr];

  // status
  always_comb begin
    fstat.empty = (count == '0);
    fstat.room1 = (count < CW'(DEPTH));
    fstat.room2 = (count < CW'(DEPTH - 1));
  end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8lc_back.sv =====
// utf8lc_back: walks the job at the queue head and presents its bytes one at a time.
// Depends on utf8lc_pkg for job_t.
`default_nettype none

module utf8lc_back
  import utf8lc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  wire job_t       head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            text_last
);

  logic [1:0] pos;
  logic       take;

  assign out_valid = head_valid;
  assign take      = out_valid && !out_stall;

  // byte select within the job
  always_comb begin
    case (pos)
      2'd0:    out_byte = head.bytes[0];
      2'd1:    out_byte = head.bytes[1];
      2'd2:    out_byte = head.bytes[2];
      default: out_byte = head.bytes[0];
    endcase
  end

  assign run_last  = (pos == head.count - 2'd1);
  assign text_last = run_last && head.last;
  assign pop       = take && run_last;

  // position inside the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 2'd0;
    end else if (take) begin
      pos <= run_last ? 2'd0 : pos + 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8lc_checker.sv =====
// utf8lc_checker: port-level assertions for utf8_lowercase_stream, bound to the top.
// Depends on utf8_lowercase_stream_macros.svh.
`default_nettype none
`include "utf8_lowercase_stream_macros.svh"

module utf8lc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       run_last,
  input wire logic       text_last
);

  // a stalled output byte holds
  `UTF8LC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(run_last) && $stable(text_last))

  // end of text always closes a run
  `UTF8LC_ASSERT_IMPLY(a_text_last_run, clk, rst, out_valid && text_last, run_last)

  // a multi-byte run continues with no gap
  `UTF8LC_ASSERT_NEXT(a_run_cont, clk, rst, out_valid && !out_stall && !run_last, out_valid)

  // requests are held off once reset falls, as the map clearing begins
  `UTF8LC_ASSERT_ALWAYS(a_clear_stall, clk, $past(rst) && !rst, in_stall)

endmodule

bind utf8_lowercase_stream utf8lc_checker u_chk (.*);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench for utf8_lowercase_stream (UTF-8 lowercasing of a byte stream).
// Depends on utf8lc_pkg and the utf8_lowercase_stream RTL; needs nothing else.

module tb;
  import utf8lc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // one output byte as the block should produce it
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_last;
  } lowered_beat_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic              func      = FUNC_TEXT;
  logic [7:0]        in_byte   = 8'h00;
  logic              last_byte = 1'b0;
  logic [MAP_AW-1:0] map_index = '0;
  logic [MAP_DW-1:0] map_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_byte;
  logic              run_last;
  logic              text_last;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int items_sent     = 0;
  int unsigned cycle_count = 0;

  // predictor state: lowercase table and the pending sequence
  logic [MAP_DW-1:0] lower_tbl [0:MAP_DEPTH-1];
  logic [7:0]        seq_lead;
  logic [7:0]        seq_second;
  logic [1:0]        seq_held;
  logic [1:0]        copy_left;
  logic [7:0]        beat_buf [0:2];
  int                beat_n;

  lowered_beat_t lowered_q [$];
  logic [7:0]    text_bytes [$];

  utf8_lowercase_stream dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .map_index (map_index),
    .map_value (map_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .text_last (text_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("utf8_lowercase_stream regression: fail");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------- predictor

  function automatic void push_beat(input logic [7:0] b);
    if (beat_n < 3) begin
      beat_buf[beat_n] = b;
      beat_n++;
    end
  endfunction

  function automatic logic [7:0] fold_ascii(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
  endfunction

  // byte seen outside any sequence
  function automatic void lower_start(input logic [7:0] b, input logic lst);
    if (b < 8'h80) begin
      push_beat(fold_ascii(b));
    end else if (b < 8'hC2 || lst) begin
      push_beat(b);
    end else if (b < 8'hF0) begin
      seq_lead = b;
      seq_held = 2'd1;
    end else begin
      push_beat(b);
      copy_left = 2'd3;
    end
  endfunction

  // two-byte sequence through the table, re-encoded
  function automatic void lower_pair(input logic [7:0] lead, input logic [7:0] second);
    logic [7:0]        lead_off;
    logic [MAP_AW-1:0] tbl_idx;
    logic [10:0]       cp;
    lead_off = lead - 8'hC2;
    tbl_idx  = {lead_off[4:0], second[5:0]};
    cp       = tbl_idx + 11'h080;
    if (lower_tbl[tbl_idx] != '0) cp = lower_tbl[tbl_idx];
    push_beat({3'b110, cp[10:6]});
    push_beat({2'b10, cp[5:0]});
  endfunction

  // fixed three-byte rules: Georgian, Latin Extended Additional, fullwidth
  function automatic void lower_triple(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2);
    logic [7:0] o0, o1, o2;
    o0 = b0;
    o1 = b1;
    o2 = b2;
    if (b0 == 8'hE1) begin
      if (b1 == 8'h82 && b2 >= 8'hA0) begin
        o0 = 8'hE2;
        o1 = 8'hB4;
        o2 = b2 - 8'h20;
      end else if (b1 == 8'h83 && b2 >= 8'h80 && b2 <= 8'h85) begin
        o0 = 8'hE2;
        o1 = 8'hB4;
        o2 = b2 + 8'h20;
      end else if (b1 >= 8'hB8 && b1 <= 8'hBB && !b2[0] && !(b1 == 8'hBA && b2 == 8'h9E)) begin
        o2 = b2 + 8'h01;
      end
    end else if (b0 == 8'hEF && b1 == 8'hBC && b2 >= 8'hA1 && b2 <= 8'hBA) begin
      o1 = 8'hBD;
      o2 = b2 - 8'h20;
    end
    push_beat(o0);
    push_beat(o1);
    push_beat(o2);
  endfunction

  // advance the predictor by one accepted request, queue the bytes it yields
  function automatic void lower_request(input logic f, input logic [7:0] b, input logic lst,
                                        input logic [MAP_AW-1:0] idx,
                                        input logic [MAP_DW-1:0] val);
    lowered_beat_t beat;
    beat_n = 0;
    if (f == FUNC_MAP) begin
      if (idx < MAP_DEPTH) lower_tbl[idx] = val;
      return;
    end
    if (copy_left != 2'd0) begin
      push_beat(b);
      copy_left = copy_left - 2'd1;
    end else if (seq_held == 2'd1) begin
      if (seq_lead < 8'hE0) begin
        lower_pair(seq_lead, b);
        seq_held = 2'd0;
      end else if (lst) begin
        // three-byte lead cut short: lead goes out raw, byte starts afresh
        push_beat(seq_lead);
        seq_held = 2'd0;
        lower_start(b, 1'b1);
      end else begin
        seq_second = b;
        seq_held   = 2'd2;
      end
    end else if (seq_held == 2'd2) begin
      lower_triple(seq_lead, seq_second, b);
      seq_held = 2'd0;
    end else begin
      lower_start(b, lst);
    end
    if (lst) begin
      seq_held  = 2'd0;
      copy_left = 2'd0;
    end
    for (int k = 0; k < beat_n; k++) begin
      beat.data      = beat_buf[k];
      beat.run_last  = (k == beat_n - 1);
      beat.text_last = (k == beat_n - 1) && lst;
      lowered_q.push_back(beat);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_output
    lowered_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (lowered_q.size() == 0) begin
        report_mismatch("unexpected output byte", int'(out_byte), 0);
      end else begin
        want = lowered_q.pop_front();
        if (out_byte !== want.data)
          report_mismatch("out_byte", int'(out_byte), int'(want.data));
        if (run_last !== want.run_last)
          report_mismatch("run_last", int'(run_last), int'(want.run_last));
        if (text_last !== want.text_last)
          report_mismatch("text_last", int'(text_last), int'(want.text_last));
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // present one request, hold it until accepted, then predict
  task automatic send_request(input logic f, input logic [7:0] b, input logic lst,
                              input logic [MAP_AW-1:0] idx, input logic [MAP_DW-1:0] val);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid  <= 1'b1;
    func      <= f;
    in_byte   <= b;
    last_byte <= lst;
    map_index <= idx;
    map_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lower_request(f, b, lst, idx, val);
    items_sent++;
  endtask

  // text byte; map fields carry junk
  task automatic send_text_byte(input logic [7:0] b, input logic lst);
    send_request(FUNC_TEXT, b, lst, MAP_AW'($urandom_range(2047)),
                 MAP_DW'($urandom_range(2047)));
  endtask

  // table write; byte and last carry junk
  task automatic send_map_write(input logic [MAP_AW-1:0] idx, input logic [MAP_DW-1:0] val);
    send_request(FUNC_MAP, 8'($urandom_range(255)), 1'($urandom_range(1)), idx, val);
  endtask

  function automatic logic [7:0] rand_byte(input int lo, input int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  // append one random character, mostly well formed, to text_bytes
  task automatic add_random_char();
    int kind;
    kind = $urandom_range(99);
    if (kind < 35) begin
      text_bytes.push_back($urandom_range(1) ? rand_byte(8'h41, 8'h5A) : rand_byte(0, 127));
    end else if (kind < 55) begin
      text_bytes.push_back($urandom_range(1) ? rand_byte(8'hC2, 8'hC5)
                                             : rand_byte(8'hC2, 8'hDF));
      text_bytes.push_back($urandom_range(9) == 0 ? rand_byte(0, 255)
                                                  : rand_byte(8'h80, 8'hBF));
    end else if (kind < 80) begin
      case ($urandom_range(4))
        0: begin
          text_bytes.push_back(8'hE1);
          text_bytes.push_back(8'h82);
          text_bytes.push_back(rand_byte(8'h80, 8'hBF));
        end
        1: begin
          text_bytes.push_back(8'hE1);
          text_bytes.push_back(8'h83);
          text_bytes.push_back(rand_byte(8'h80, 8'h87));
        end
        2: begin
          text_bytes.push_back(8'hE1);
          text_bytes.push_back(rand_byte(8'hB8, 8'hBB));
          text_bytes.push_back($urandom_range(3) == 0 ? 8'h9E : rand_byte(8'h80, 8'hBF));
        end
        3: begin
          text_bytes.push_back(8'hEF);
          text_bytes.push_back(8'hBC);
          text_bytes.push_back(rand_byte(8'h9F, 8'hBC));
        end
        default: begin
          text_bytes.push_back(rand_byte(8'hE0, 8'hEF));
          text_bytes.push_back(rand_byte(8'h80, 8'hBF));
          text_bytes.push_back(rand_byte(0, 255));
        end
      endcase
    end else if (kind < 88) begin
      text_bytes.push_back(rand_byte(8'hF0, 8'hFF));
      repeat (3) text_bytes.push_back(rand_byte(0, 255));
    end else begin
      text_bytes.push_back(rand_byte(8'h80, 8'hC1));
    end
  endtask

  // one random text, sometimes cut mid-sequence, with table writes mixed in
  task automatic send_random_text(input int n_chars);
    int r;
    int cut;
    int idx;
    text_bytes.delete();
    repeat (n_chars) add_random_char();
    if ($urandom_range(99) < 15 && text_bytes.size() > 1) begin
      cut = $urandom_range(text_bytes.size() > 2 ? 2 : 1, 1);
      repeat (cut) void'(text_bytes.pop_back());
    end
    for (int i = 0; i < text_bytes.size(); i++) begin
      if ($urandom_range(99) < 12) begin
        r   = $urandom_range(99);
        idx = (r < 70) ? $urandom_range(255) :
              (r < 90) ? $urandom_range(MAP_DEPTH - 1) : $urandom_range(2047, MAP_DEPTH);
        send_map_write(MAP_AW'(idx),
                       $urandom_range(4) == 0 ? '0 : MAP_DW'($urandom_range(2047)));
      end
      send_text_byte(text_bytes[i], i == text_bytes.size() - 1);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_ascii_and_stray();
    send_text_byte(8'h41, 1'b0);   // 'A'
    send_text_byte(8'h40, 1'b0);   // just below 'A'
    send_text_byte(8'h5A, 1'b0);   // 'Z'
    send_text_byte(8'h80, 1'b0);   // stray continuation
    send_text_byte(8'hC1, 1'b0);   // overlong lead, copied
  endtask

  task automatic test_two_byte_map();
    send_map_write(11'd0, 11'h0E1);
    send_text_byte(8'hC2, 1'b0);
    send_map_write(11'd5, 11'h041);        // write while a lead is pending
    send_text_byte(8'h80, 1'b0);           // C2 80 -> C3 A1
    send_map_write(11'h7FF, 11'h155);      // out of range, dropped
    send_map_write(11'd1919, 11'h080);
    send_text_byte(8'hC2, 1'b0);
    send_text_byte(8'h85, 1'b0);           // lowered value below 0x80
    send_text_byte(8'hDF, 1'b0);
    send_text_byte(8'hBF, 1'b0);           // top table entry
  endtask

  task automatic test_three_byte_rules();
    send_text_byte(8'hE1, 1'b0);
    send_text_byte(8'h82, 1'b0);
    send_text_byte(8'hA0, 1'b0);           // Georgian
    send_text_byte(8'hEF, 1'b0);
    send_text_byte(8'hBC, 1'b0);
    send_text_byte(8'hA1, 1'b0);           // fullwidth
  endtask

  task automatic test_cut_short();
    send_text_byte(8'hF0, 1'b0);
    send_text_byte(8'h90, 1'b1);           // four-byte copy stops at end of text
    send_text_byte(8'hE1, 1'b0);
    send_text_byte(8'h51, 1'b1);           // lead flushed raw, then 'Q' lowered
    send_text_byte(8'hC3, 1'b1);           // lead as final byte
  endtask

  task automatic test_random_text(input int n_items, input int gap_pct, input int stall_pct);
    int stop_at;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    stop_at        = items_sent + n_items;
    while (items_sent < stop_at) send_random_text($urandom_range(10, 1));
  endtask

  initial begin
    for (int i = 0; i < MAP_DEPTH; i++) lower_tbl[i] = '0;
    seq_lead   = 8'h00;
    seq_second = 8'h00;
    seq_held   = 2'd0;
    copy_left  = 2'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_gap_pct   = 30;
    recv_stall_pct = 83;
    test_ascii_and_stray();
    test_two_byte_map();
    test_three_byte_rules();
    test_cut_short();
    test_random_text(50, 30, 83);
    test_random_text(50, 83, 30);
    test_random_text(50, 0, 0);

    in_valid <= 1'b0;
    while (lowered_q.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("utf8_lowercase_stream regression: pass");
    end else begin
      $display("utf8_lowercase_stream regression: fail");
    end
    $finish;
  end

endmodule

// ===== utf8_lowercase_stream.f =====
+incdir+hw/rtl
hw/rtl/utf8lc_pkg.sv
hw/rtl/utf8lc_front.sv
hw/rtl/utf8lc_fifo.sv
hw/rtl/utf8lc_back.sv
hw/rtl/utf8_lowercase_stream.sv
hw/rtl/utf8lc_checker.sv
dv/tb.sv
